// ===== rtl/core/cek_pkg.sv =====
package cek_pkg;

  localparam int OUT_FRAC_BITS_DEF = 28;
  localparam int LOG_STEPS         = 32;
  localparam int HORNER_STEPS      = 9;
  localparam int NUM_POLY          = 4;
  localparam int NUM_COEF          = HORNER_STEPS + 1;
  localparam int PIPE_STAGES       = LOG_STEPS + 3;

  localparam logic [31:0] Y_ONE   = 32'h8000_0000;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Horner sums, Q.32 with headroom
  typedef logic [39:0] sum_t;
  // K or E before output rounding, Q.32
  typedef logic [47:0] acc_t;

  localparam int POLY_A = 0;
  localparam int POLY_B = 1;
  localparam int POLY_C = 2;
  localparam int POLY_D = 3;

  // Q.32, highest degree first
  localparam sum_t POLY_COEF [NUM_POLY][NUM_COEF] = '{
    '{40'd1291605, 40'd17044453, 40'd46368426, 40'd45483504, 40'd32295520,
      40'd38339654, 40'd64175527, 40'd132650808, 40'd414780412, 40'd5954088944},
    '{40'd286181, 40'd7394279, 40'd39862280, 40'd88863904, 40'd126717553,
      40'd160354952, 40'd209711034, 40'd301989868, 40'd536870912, 40'd2147483648},
    '{40'd1396689, 40'd18479259, 40'd50619802, 40'd50860685, 40'd38807296,
      40'd50323131, 40'd93785470, 40'd243976576, 40'd1903302648, 40'd4294967296},
    '{40'd309374, 40'd8008129, 40'd43327452, 40'd97325290, 40'd140922469,
      40'd183277035, 40'd251653761, 40'd402653163, 40'd1073741824, 40'd0}
  };

endpackage

// ===== rtl/core/cek_pipe.sv =====
module cek_pipe (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [31:0]   y_in,
  output logic          out_vld,
  output cek_pkg::acc_t k_acc,
  output cek_pkg::acc_t e_acc
);

  localparam int LS = cek_pkg::LOG_STEPS;
  localparam int HS = cek_pkg::HORNER_STEPS;
  localparam int NS = cek_pkg::PIPE_STAGES;

  // round-half-up Q.32 product, s below 2^40, q at most 2^32
  function automatic cek_pkg::sum_t mul_sy(cek_pkg::sum_t s, logic [32:0] q);
    logic [63:0] lo;
    logic [40:0] r;
    lo = {32'd0, s[31:0]} * {32'd0, q[31:0]} + 64'h8000_0000;
    r = {1'b0, (q[32] ? s[39:32] : 8'd0), 32'd0}
      + ({33'd0, s[39:32]} * {9'd0, q[31:0]})
      + (q[32] ? {9'd0, s[31:0]} : 41'd0)
      + {9'd0, lo[63:32]};
    return r[39:0];
  endfunction

  // one squaring of the mantissa, Q1.31 in, Q2.31 out
  function automatic logic [32:0] sq_step(logic [31:0] f);
    logic [63:0] sq;
    sq = {32'd0, f} * {32'd0, f} + 64'h4000_0000;
    return sq[63:31];
  endfunction

  function automatic logic [36:0] mul_ln2(logic [36:0] x);
    logic [63:0] lo;
    lo = {32'd0, x[31:0]} * {32'd0, cek_pkg::LN2_Q32} + 64'h8000_0000;
    return ({32'd0, x[36:32]} * {5'd0, cek_pkg::LN2_Q32}) + {5'd0, lo[63:32]};
  endfunction

  function automatic cek_pkg::acc_t mul_bl(cek_pkg::sum_t b, logic [36:0] l);
    logic [63:0] lo;
    logic [12:0] hh;
    lo = {32'd0, b[31:0]} * {32'd0, l[31:0]} + 64'h8000_0000;
    hh = {5'd0, b[39:32]} * {8'd0, l[36:32]};
    return {3'd0, hh, 32'd0}
      + ({40'd0, b[39:32]} * {16'd0, l[31:0]})
      + ({16'd0, b[31:0]} * {43'd0, l[36:32]})
      + {16'd0, lo[63:32]};
  endfunction

  logic [NS-1:0] vld_r;

  logic [31:0]      f_r  [0:LS-1];
  logic [31:0]      fr_r [1:LS];
  logic [4:0]       n_r  [0:LS];
  logic [32:0]      yq_r [0:HS-1];
  cek_pkg::sum_t    hs_r [cek_pkg::NUM_POLY][0:LS];
  cek_pkg::sum_t    hl_r [cek_pkg::NUM_POLY];
  logic [36:0]      lnl_r;
  cek_pkg::acc_t    k_acc_r, e_acc_r;

  // clamp and normalize
  logic [31:0] yc;
  logic [4:0]  nz;
  always_comb begin
    if (y_in == 32'd0) begin
      yc = 32'd1;
    end else if (y_in > cek_pkg::Y_ONE) begin
      yc = cek_pkg::Y_ONE;
    end else begin
      yc = y_in;
    end
    nz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (yc[i]) nz = 5'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0]  <= yc << nz;
      n_r[0]  <= nz;
      yq_r[0] <= {yc, 1'b0};
    end
  end

  for (genvar p = 0; p < cek_pkg::NUM_POLY; p++) begin : g_seed
    always_ff @(posedge clk) begin
      if (adv) begin
        hs_r[p][0] <= cek_pkg::POLY_COEF[p][0];
      end
    end
  end

  for (genvar j = 0; j < LS; j++) begin : g_log
    logic [32:0] sq;
    assign sq = sq_step(f_r[j]);
    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[j+1] <= n_r[j];
      end
    end
    if (j < LS - 1) begin : g_f
      always_ff @(posedge clk) begin
        if (adv) begin
          f_r[j+1] <= sq[32] ? sq[32:1] : sq[31:0];
        end
      end
    end
    if (j == 0) begin : g_fr0
      always_ff @(posedge clk) begin
        if (adv) begin
          fr_r[1] <= {31'd0, sq[32]};
        end
      end
    end else begin : g_frn
      always_ff @(posedge clk) begin
        if (adv) begin
          fr_r[j+1] <= {fr_r[j][30:0], sq[32]};
        end
      end
    end
    if (j < HS) begin : g_horner
      if (j < HS - 1) begin : g_yq
        always_ff @(posedge clk) begin
          if (adv) begin
            yq_r[j+1] <= yq_r[j];
          end
        end
      end
      for (genvar p = 0; p < cek_pkg::NUM_POLY; p++) begin : g_hp
        always_ff @(posedge clk) begin
          if (adv) begin
            hs_r[p][j+1] <= mul_sy(hs_r[p][j], yq_r[j])
                          + cek_pkg::POLY_COEF[p][j+1];
          end
        end
      end
    end else begin : g_carry
      for (genvar p = 0; p < cek_pkg::NUM_POLY; p++) begin : g_cp
        always_ff @(posedge clk) begin
          if (adv) begin
            hs_r[p][j+1] <= hs_r[p][j];
          end
        end
      end
    end
  end

  // -ln(y) = (n - log2 f) * ln2
  always_ff @(posedge clk) begin
    if (adv) begin
      lnl_r <= mul_ln2({n_r[LS], 32'd0} - {5'd0, fr_r[LS]});
      for (int p = 0; p < cek_pkg::NUM_POLY; p++) begin
        hl_r[p] <= hs_r[p][LS];
      end
      k_acc_r <= {8'd0, hl_r[cek_pkg::POLY_A]} + mul_bl(hl_r[cek_pkg::POLY_B], lnl_r);
      e_acc_r <= {8'd0, hl_r[cek_pkg::POLY_C]} + mul_bl(hl_r[cek_pkg::POLY_D], lnl_r);
    end
  end

  assign out_vld = vld_r[NS-1];
  assign k_acc   = k_acc_r;
  assign e_acc   = e_acc_r;

endmodule

// ===== rtl/core/complete_elliptic_integrals_k_e.sv =====
// Stages an accepted item passes through, in order:
// (normalize, 32 squaring steps of the log unit, ln2 scale, B*L / D*L, output).
// Throughput: one item per cycle while in_stall is low; Horner runs beside the log unit.
// A two-entry output buffer keeps the pipeline moving while one result waits.
// Reset: synchronous, active low; clears all valid bits, the pipeline drains empty.
module complete_elliptic_integrals_k_e #(
  parameter int OUT_FRAC_BITS = cek_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_y_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_k_value,
  output logic [31:0] out_e_value
);

  function automatic logic [31:0] to_out(cek_pkg::acc_t x);
    logic [48:0] t;
    t = {1'b0, x} + (49'd1 << (31 - OUT_FRAC_BITS));
    t = t >> (32 - OUT_FRAC_BITS);
    return (|t[48:32]) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  logic          adv;
  logic          p_vld;
  cek_pkg::acc_t p_k, p_e;
  logic [31:0]   q_k, q_e;

  logic          out_vld_r;
  logic [31:0]   out_k_r, out_e_r;
  logic          skid_vld_r;
  logic [31:0]   skid_k_r, skid_e_r;

  assign adv = !skid_vld_r;

  cek_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .y_in    (in_y_value),
    .out_vld (p_vld),
    .k_acc   (p_k),
    .e_acc   (p_e)
  );

  assign q_k = to_out(p_k);
  assign q_e = to_out(p_e);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        out_k_r    <= skid_k_r;
        out_e_r    <= skid_e_r;
        skid_vld_r <= 1'b0;
      end else if (p_vld) begin
        out_vld_r <= 1'b1;
        out_k_r   <= q_k;
        out_e_r   <= q_e;
      end else begin
        out_vld_r <= 1'b0;
      end
    end else if (adv && p_vld) begin
      skid_vld_r <= 1'b1;
      skid_k_r   <= q_k;
      skid_e_r   <= q_e;
    end
  end

  assign in_stall    = skid_vld_r;
  assign out_valid   = out_vld_r;
  assign out_k_value = out_k_r;
  assign out_e_value = out_e_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held without an output item");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && out_stall && p_vld))
    else $error("skid filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_stall) |=> (out_vld_r && !skid_vld_r))
    else $error("skid item not moved to output");

endmodule
